@@ hdl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers, reset-qualified on arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// Expression must never be true outside reset.
`define ASSERT_NEVER(label, expr, msg) \
	`ASSERT_CLK(label, !(expr), msg)

`endif

@@ hdl/tsrl_pkg.sv @@
// ----------------------------------------------------------------------------
// tsrl_pkg
// Shared types and constants for the tour segment reversal length block.
// ----------------------------------------------------------------------------
package tsrl_pkg;

	localparam int CITY_COUNT_DEF = 64;
	localparam int COORD_BITS_DEF = 10;

	localparam int REQ_W      = 2;
	localparam int IDX_W      = 6;
	localparam int COORD_IN_W = 10;
	localparam int LEN_W      = 17;

	localparam logic [LEN_W-1:0] LEN_MAX = '1;

	typedef enum logic [REQ_W-1:0] {
		REQ_LOAD = 2'd0,
		REQ_MOVE = 2'd1,
		REQ_READ = 2'd2,
		REQ_NONE = 2'd3
	} req_t;

	typedef struct packed {
		logic accept;
		logic load_wr;
		logic inval;
		logic walk_init;
		logic walk_issue;
		logic clr_step;
		logic swap_rd;
		logic swap_wr_hi;
		logic swap_wr_lo;
		logic rd_issue;
		logic set_before;
		logic set_after;
		logic set_city;
		logic out_push;
	} dp_cmd_t;

	typedef struct packed {
		logic k_last;
		logic len_valid;
		logic walk_done;
		logic idx_ok;
		logic move_ok;
		logic swap_any;
		logic swap_more;
		logic out_free;
	} dp_stat_t;

endpackage

@@ hdl/tsrl_ctrl.sv @@
// ----------------------------------------------------------------------------
// tsrl_ctrl
// Request sequencer: clear pass, loads, length walks, segment swaps, reads, result push.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsrl_ctrl
	import tsrl_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  logic [REQ_W-1:0] req_type,
	input  dp_stat_t         stat,
	output dp_cmd_t          cmd
);

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_WALK1,
		S_WAIT1,
		S_BEFORE,
		S_SW_RD,
		S_SW_WH,
		S_SW_WL,
		S_WALK2,
		S_WAIT2,
		S_AFTER,
		S_RD_WAIT,
		S_DONE
	} state_t;

	state_t state_q, state_d;
	req_t   req_q;
	logic   accept;

	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (stat.k_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (accept) begin
					cmd.accept = 1'b1;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				case (req_q)
					REQ_LOAD: begin
						if (stat.idx_ok) begin
							cmd.load_wr = 1'b1;
							cmd.inval   = 1'b1;
						end
						state_d = S_DONE;
					end
					REQ_MOVE: begin
						state_d = stat.len_valid ? S_BEFORE : S_WALK1;
					end
					REQ_READ: begin
						if (stat.idx_ok) begin
							cmd.rd_issue = 1'b1;
							state_d      = S_RD_WAIT;
						end else begin
							state_d = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_WALK1: begin
				cmd.walk_issue = 1'b1;
				if (stat.k_last) begin
					state_d = S_WAIT1;
				end
			end
			S_WAIT1: begin
				if (stat.walk_done) begin
					state_d = S_BEFORE;
				end
			end
			S_BEFORE: begin
				cmd.set_before = 1'b1;
				cmd.walk_init  = 1'b1;
				if (!stat.move_ok) begin
					state_d = S_AFTER;
				end else begin
					cmd.inval = 1'b1;
					state_d   = stat.swap_any ? S_SW_RD : S_WALK2;
				end
			end
			S_SW_RD: begin
				cmd.swap_rd = 1'b1;
				state_d     = S_SW_WH;
			end
			S_SW_WH: begin
				cmd.swap_wr_hi = 1'b1;
				state_d        = S_SW_WL;
			end
			S_SW_WL: begin
				cmd.swap_wr_lo = 1'b1;
				state_d        = stat.swap_more ? S_SW_RD : S_WALK2;
			end
			S_WALK2: begin
				cmd.walk_issue = 1'b1;
				if (stat.k_last) begin
					state_d = S_WAIT2;
				end
			end
			S_WAIT2: begin
				if (stat.walk_done) begin
					state_d = S_AFTER;
				end
			end
			S_AFTER: begin
				cmd.set_after = 1'b1;
				state_d       = S_DONE;
			end
			S_RD_WAIT: begin
				cmd.set_city = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.out_push = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			req_q   <= REQ_LOAD;
		end else begin
			state_q <= state_d;
			if (accept) begin
				req_q <= req_t'(req_type);
			end
		end
	end

	`ASSERT_CLK(a_cmd_excl, $onehot0({cmd.clr_step, cmd.walk_issue, cmd.swap_rd, cmd.swap_wr_hi, cmd.swap_wr_lo, cmd.rd_issue}), "tsrl_ctrl: conflicting memory commands")
	`ASSERT_CLK(a_push_free, cmd.out_push |-> stat.out_free, "tsrl_ctrl: push into full output")
	`ASSERT_CLK(a_accept_decode, accept |=> (state_q == S_DECODE), "tsrl_ctrl: request not decoded")

endmodule

@@ hdl/tsrl_dp.sv @@
// ----------------------------------------------------------------------------
// tsrl_dp
// Tour and coordinate memories, length walk pipeline, swap pointers, results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tsrl_dp
	import tsrl_pkg::*;
#(
	parameter int CITY_COUNT = CITY_COUNT_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  dp_cmd_t               cmd,
	output dp_stat_t              stat,
	input  logic [IDX_W-1:0]      city_index,
	input  logic [IDX_W-1:0]      pos_a,
	input  logic [IDX_W-1:0]      pos_b,
	input  logic [COORD_IN_W-1:0] coord_x,
	input  logic [COORD_IN_W-1:0] coord_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEN_W-1:0]      length_before,
	output logic [LEN_W-1:0]      length_after,
	output logic [IDX_W-1:0]      tour_city
);

	localparam int POS_W = $clog2(CITY_COUNT);
	localparam int SUM_W = COORD_BITS + 1 + POS_W;
	localparam int XY_W  = 2 * COORD_BITS;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(CITY_COUNT - 1);

	// request capture
	logic [IDX_W-1:0]            idx_q;
	logic [POS_W-1:0]            lo_q, hi_q;
	logic [COORD_BITS-1:0]       cx_q, cy_q;
	logic                        idx_ok_q, move_ok_q;
	logic [IDX_W-1:0]            lo_in, hi_in;
	logic [POS_W+IDX_W-1:0]      lo_ext, hi_ext, idx_ext;
	logic [COORD_BITS+COORD_IN_W-1:0] cx_ext, cy_ext;
	logic [POS_W-1:0]            idx_pos;

	assign lo_in   = (pos_a < pos_b) ? pos_a : pos_b;
	assign hi_in   = (pos_a < pos_b) ? pos_b : pos_a;
	assign lo_ext  = {{POS_W{1'b0}}, lo_in};
	assign hi_ext  = {{POS_W{1'b0}}, hi_in};
	assign idx_ext = {{POS_W{1'b0}}, idx_q};
	assign idx_pos = idx_ext[POS_W-1:0];
	assign cx_ext  = {{COORD_BITS{1'b0}}, coord_x};
	assign cy_ext  = {{COORD_BITS{1'b0}}, coord_y};

	// memories
	logic [POS_W-1:0] tour_mem [CITY_COUNT];
	logic [XY_W-1:0]  xy_mem [CITY_COUNT];
	logic [POS_W-1:0] rda_q, rdb_q;
	logic [XY_W-1:0]  xy_q;
	logic [POS_W-1:0] rda_addr, t_waddr, t_wdata;
	logic             rda_en, t_we;
	logic [POS_W-1:0] k_q;

	// walk pipeline
	logic                  v_s1, first_s1, last_s1;
	logic                  v_s2, first_s2, last_s2;
	logic                  close_s3, fin_s4, done_s5;
	logic [XY_W-1:0]       first_q, prev_q, opp;
	logic [COORD_BITS-1:0] dx, dy;
	logic [COORD_BITS:0]   edge_dist;
	logic [SUM_W-1:0]      sum_q;
	logic [SUM_W+LEN_W-1:0] sum_ext;
	logic [LEN_W-1:0]      sat_len;
	logic [LEN_W-1:0]      cached_q;
	logic                  len_valid_q;

	// results
	logic [LEN_W-1:0]       before_q, after_q;
	logic [IDX_W-1:0]       city_q;
	logic [POS_W+IDX_W-1:0] city_ext;
	logic                   out_valid_q;
	logic [LEN_W-1:0]       length_before_q, length_after_q;
	logic [IDX_W-1:0]       tour_city_q;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			idx_q     <= city_index;
			lo_q      <= lo_ext[POS_W-1:0];
			hi_q      <= hi_ext[POS_W-1:0];
			cx_q      <= cx_ext[COORD_BITS-1:0];
			cy_q      <= cy_ext[COORD_BITS-1:0];
			idx_ok_q  <= (32'(city_index) < 32'(CITY_COUNT));
			move_ok_q <= (32'(pos_a) < 32'(CITY_COUNT)) && (32'(pos_b) < 32'(CITY_COUNT));
		end else if (cmd.swap_wr_lo) begin
			lo_q <= lo_q + POS_W'(1);
			hi_q <= hi_q - POS_W'(1);
		end
	end

	always_comb begin
		rda_en = cmd.walk_issue || cmd.swap_rd || cmd.rd_issue;
		if (cmd.walk_issue) begin
			rda_addr = k_q;
		end else if (cmd.swap_rd) begin
			rda_addr = lo_q;
		end else begin
			rda_addr = idx_pos;
		end
		t_we = cmd.clr_step || cmd.swap_wr_hi || cmd.swap_wr_lo;
		if (cmd.clr_step) begin
			t_waddr = k_q;
			t_wdata = k_q;
		end else if (cmd.swap_wr_hi) begin
			t_waddr = hi_q;
			t_wdata = rda_q;
		end else begin
			t_waddr = lo_q;
			t_wdata = rdb_q;
		end
	end

	always_ff @(posedge clk) begin
		if (t_we) begin
			tour_mem[t_waddr] <= t_wdata;
		end
		if (rda_en) begin
			rda_q <= tour_mem[rda_addr];
		end
		if (cmd.swap_rd) begin
			rdb_q <= tour_mem[hi_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr_step) begin
			xy_mem[k_q] <= '0;
		end else if (cmd.load_wr) begin
			xy_mem[idx_pos] <= {cx_q, cy_q};
		end
		if (v_s1) begin
			xy_q <= xy_mem[rda_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
		end else if (cmd.accept || cmd.walk_init) begin
			k_q <= '0;
		end else if (cmd.clr_step || cmd.walk_issue) begin
			k_q <= k_q + POS_W'(1);
		end
	end

	// edge distance: previous city against current, or last against first
	assign opp  = close_s3 ? first_q : xy_q;
	assign dx   = (prev_q[XY_W-1:COORD_BITS] > opp[XY_W-1:COORD_BITS]) ?
		prev_q[XY_W-1:COORD_BITS] - opp[XY_W-1:COORD_BITS] :
		opp[XY_W-1:COORD_BITS] - prev_q[XY_W-1:COORD_BITS];
	assign dy   = (prev_q[COORD_BITS-1:0] > opp[COORD_BITS-1:0]) ?
		prev_q[COORD_BITS-1:0] - opp[COORD_BITS-1:0] :
		opp[COORD_BITS-1:0] - prev_q[COORD_BITS-1:0];
	assign edge_dist = {1'b0, dx} + {1'b0, dy};

	assign sum_ext = {{LEN_W{1'b0}}, sum_q};
	assign sat_len = (sum_ext > (SUM_W+LEN_W)'(LEN_MAX)) ? LEN_MAX : sum_ext[LEN_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1     <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			v_s2     <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			close_s3 <= 1'b0;
			fin_s4   <= 1'b0;
			done_s5  <= 1'b0;
		end else begin
			v_s1     <= cmd.walk_issue;
			first_s1 <= cmd.walk_issue && (k_q == '0);
			last_s1  <= cmd.walk_issue && (k_q == POS_LAST);
			v_s2     <= v_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			close_s3 <= v_s2 && last_s2;
			fin_s4   <= close_s3;
			done_s5  <= fin_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (v_s2) begin
			prev_q <= xy_q;
			if (first_s2) begin
				first_q <= xy_q;
				sum_q   <= '0;
			end else begin
				sum_q <= sum_q + SUM_W'(edge_dist);
			end
		end else if (close_s3) begin
			sum_q <= sum_q + SUM_W'(edge_dist);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cached_q    <= '0;
			len_valid_q <= 1'b0;
		end else if (cmd.load_wr || cmd.inval) begin
			len_valid_q <= 1'b0;
		end else if (fin_s4) begin
			cached_q    <= sat_len;
			len_valid_q <= 1'b1;
		end
	end

	assign city_ext = {{IDX_W{1'b0}}, rda_q};

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			before_q <= '0;
			after_q  <= '0;
			city_q   <= '0;
		end else begin
			if (cmd.set_before) begin
				before_q <= cached_q;
			end
			if (cmd.set_after) begin
				after_q <= cached_q;
			end
			if (cmd.set_city) begin
				city_q <= city_ext[IDX_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_push) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_push) begin
			length_before_q <= before_q;
			length_after_q  <= after_q;
			tour_city_q     <= city_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign length_before = length_before_q;
	assign length_after  = length_after_q;
	assign tour_city     = tour_city_q;

	assign stat.k_last    = (k_q == POS_LAST);
	assign stat.len_valid = len_valid_q;
	assign stat.walk_done = done_s5;
	assign stat.idx_ok    = idx_ok_q;
	assign stat.move_ok   = move_ok_q;
	assign stat.swap_any  = (hi_q > lo_q);
	assign stat.swap_more = (({1'b0, hi_q} - (POS_W+1)'(1)) > ({1'b0, lo_q} + (POS_W+1)'(1)));
	assign stat.out_free  = !out_valid_q || !out_stall;

	`ASSERT_CLK(a_done_valid, done_s5 |-> len_valid_q, "tsrl_dp: walk done without valid length")
	`ASSERT_CLK(a_swap_order, (cmd.swap_wr_hi || cmd.swap_wr_lo) |-> (lo_q < hi_q), "tsrl_dp: swap pointers crossed")
	`ASSERT_NEVER(a_walk_overlap, close_s3 && v_s2, "tsrl_dp: closing edge overlaps walk")

endmodule

@@ hdl/tour_segment_reversal_length.sv @@
// ----------------------------------------------------------------------------
// tour_segment_reversal_length
// Closed tour with coordinate table: loads, segment reversals with Manhattan
// tour length before and after, and position reads.
// ----------------------------------------------------------------------------
//  channel | signals                                               | dir
//  --------+-------------------------------------------------------+-----
//  request | in_valid in_stall req_type city_index pos_a pos_b     | in
//          | coord_x coord_y                                       |
//  result  | out_valid out_stall length_before length_after        | out
//          | tour_city                                             |
//
// After reset a clearing pass over every position sets the tour to identity
// and the coordinates to zero; in_stall stays high until it ends.
// A move walks the tour for the length before, swaps the segment pair by pair
// and walks again for the length after; each length walk streams the tour
// memory one position a cycle, and each swap costs a read and two writes on
// the single tour write port. A cached length skips the first walk. A new
// request is taken while a result waits on out_stall.
// ----------------------------------------------------------------------------
module tour_segment_reversal_length
	import tsrl_pkg::*;
#(
	parameter int CITY_COUNT = CITY_COUNT_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [REQ_W-1:0]      req_type,
	input  logic [IDX_W-1:0]      city_index,
	input  logic [IDX_W-1:0]      pos_a,
	input  logic [IDX_W-1:0]      pos_b,
	input  logic [COORD_IN_W-1:0] coord_x,
	input  logic [COORD_IN_W-1:0] coord_y,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [LEN_W-1:0]      length_before,
	output logic [LEN_W-1:0]      length_after,
	output logic [IDX_W-1:0]      tour_city
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	tsrl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	tsrl_dp #(
		.CITY_COUNT (CITY_COUNT),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.city_index    (city_index),
		.pos_a         (pos_a),
		.pos_b         (pos_b),
		.coord_x       (coord_x),
		.coord_y       (coord_y),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.length_before (length_before),
		.length_after  (length_after),
		.tour_city     (tour_city)
	);

endmodule
